// File: rtl/grst_pkg.sv
// ----------------------------------------------------------------------------
// grst_pkg: shared types and constants for the resource survival test
// Register indexes, default formats, exp constants and the pipeline tag.
// ----------------------------------------------------------------------------
package grst_pkg;

	localparam int FRAC_BITS_DEF = 8;
	localparam int PROB_BITS_DEF = 16;

	localparam int NUM_W   = 48;
	localparam int X_INT   = 22;
	localparam int X_W     = X_INT + 1;
	localparam int Y_W     = 23;
	localparam int N_W     = 7;
	localparam int M_W     = 17;
	localparam int FRAC_ST = 16;
	localparam int YEAR_W  = 5;

	localparam logic [16:0]    LOG2E_Q16 = 17'd94548;
	localparam logic [X_W-1:0] X_CAP     = X_W'(1) << X_INT;
	localparam logic [N_W-1:0] N_LIMIT   = N_W'(40);
	localparam logic [M_W-1:0] M_ONE     = M_W'(1) << 16;

	typedef enum logic [2:0] {
		REG_PEAK   = 3'd0,
		REG_OPT    = 3'd1,
		REG_GAIN   = 3'd2,
		REG_BASE   = 3'd3,
		REG_YEARS  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic        vld;
		logic        wzero;
		logic [15:0] rnd;
	} tag_t;

	function automatic logic [15:0] pow2_frac(input logic [3:0] i);
		logic [15:0] v;
		unique case (i)
			4'd0:  v = 16'd46341;
			4'd1:  v = 16'd55109;
			4'd2:  v = 16'd60097;
			4'd3:  v = 16'd62757;
			4'd4:  v = 16'd64132;
			4'd5:  v = 16'd64830;
			4'd6:  v = 16'd65182;
			4'd7:  v = 16'd65359;
			4'd8:  v = 16'd65447;
			4'd9:  v = 16'd65492;
			4'd10: v = 16'd65514;
			4'd11: v = 16'd65525;
			4'd12: v = 16'd65530;
			4'd13: v = 16'd65533;
			4'd14: v = 16'd65535;
			4'd15: v = 16'd65535;
			default: v = 16'd65535;
		endcase
		return v;
	endfunction

endpackage

// File: rtl/grst_front.sv
// ----------------------------------------------------------------------------
// grst_front: distance, curve width and divider operands
// Three stages: |R-mu| and delta*G, then width and d^2, then 2*w^2.
// ----------------------------------------------------------------------------
module grst_front #(
	parameter int FRAC_BITS = grst_pkg::FRAC_BITS_DEF,
	parameter int WW        = 33 - FRAC_BITS,
	parameter int DW        = 2 * WW + 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  grst_pkg::tag_t               tag_in,
	input  logic [15:0]                  resource_level,
	input  logic [15:0]                  growth_value,
	input  logic [15:0]                  optimum_resource,
	input  logic [15:0]                  growth_width_gain,
	input  logic [15:0]                  base_width,
	output grst_pkg::tag_t               tag_out,
	output logic [grst_pkg::NUM_W-1:0]   num_out,
	output logic [DW-1:0]                den_out
);

	grst_pkg::tag_t tag_s1, tag_s2, tag_s3;
	logic [15:0]    d_s1;
	logic [31:0]    prod_s1;
	logic [WW-1:0]  w_s2;
	logic [31:0]    d2_s2;
	logic [grst_pkg::NUM_W-1:0] num_s3;
	logic [DW-1:0]  den_s3;
	logic [2*WW-1:0] wsq;

	assign wsq = (2*WW)'(w_s2) * (2*WW)'(w_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else if (en) begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
			tag_s3 <= '{vld: tag_s2.vld, wzero: (w_s2 == '0), rnd: tag_s2.rnd};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1    <= (resource_level >= optimum_resource) ?
				resource_level - optimum_resource : optimum_resource - resource_level;
			prod_s1 <= 32'(growth_width_gain) * 32'(growth_value);
			w_s2    <= WW'(prod_s1 >> FRAC_BITS) + WW'(base_width);
			d2_s2   <= 32'(d_s1) * 32'(d_s1);
			num_s3  <= {d2_s2, 16'h0000};
			den_s3  <= {wsq, 1'b0};
		end
	end

	assign tag_out = tag_s3;
	assign num_out = num_s3;
	assign den_out = den_s3;

endmodule

// File: rtl/grst_div.sv
// ----------------------------------------------------------------------------
// grst_div: pipelined restoring divider with saturation at 64.0
// One overflow stage, then one quotient bit per stage.
// ----------------------------------------------------------------------------
module grst_div #(
	parameter int DW = 51
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  grst_pkg::tag_t             tag_in,
	input  logic [grst_pkg::NUM_W-1:0] num_in,
	input  logic [DW-1:0]              den_in,
	output grst_pkg::tag_t             tag_out,
	output logic [grst_pkg::X_W-1:0]   x_out
);

	localparam int NB = grst_pkg::X_INT;
	localparam int CW = DW + NB;

	grst_pkg::tag_t                tag_st [0:NB];
	logic [grst_pkg::NUM_W-1:0]    rem_st [0:NB];
	logic [DW-1:0]                 den_st [0:NB];
	logic [grst_pkg::X_W-1:0]      q_st   [0:NB];
	logic                          sat_st [0:NB];
	logic                          sat0;

	assign sat0 = CW'(num_in) >= (CW'(den_in) << NB);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tag_st[0] <= '0;
		else if (en) tag_st[0] <= tag_in;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_st[0] <= num_in;
			den_st[0] <= den_in;
			sat_st[0] <= sat0;
			q_st[0]   <= sat0 ? grst_pkg::X_CAP : '0;
		end
	end

	for (genvar j = 1; j <= NB; j++) begin : g_bit
		localparam int B = NB - j;
		logic [CW-1:0] shd;
		logic          ge;

		assign shd = CW'(den_st[j-1]) << B;
		assign ge  = !sat_st[j-1] && (CW'(rem_st[j-1]) >= shd);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) tag_st[j] <= '0;
			else if (en) tag_st[j] <= tag_st[j-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_st[j] <= ge ? grst_pkg::NUM_W'(CW'(rem_st[j-1]) - shd) : rem_st[j-1];
				den_st[j] <= den_st[j-1];
				sat_st[j] <= sat_st[j-1];
				q_st[j]   <= q_st[j-1] | (grst_pkg::X_W'(ge) << B);
			end
		end
	end

	assign tag_out = tag_st[NB];
	assign x_out   = q_st[NB];

endmodule

// File: rtl/grst_exp.sv
// ----------------------------------------------------------------------------
// grst_exp: yearly survival from the scaled exponent
// log2e scaling, sixteen table-multiply stages for 2^-f, rho scale, shift.
// ----------------------------------------------------------------------------
module grst_exp #(
	parameter int PROB_BITS = grst_pkg::PROB_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  grst_pkg::tag_t           tag_in,
	input  logic [grst_pkg::X_W-1:0] x_in,
	input  logic [15:0]              peak_survival,
	output grst_pkg::tag_t           tag_out,
	output logic [PROB_BITS-1:0]     p_out
);

	localparam int SHL = (PROB_BITS >= 16) ? PROB_BITS - 16 : 0;
	localparam int SHR = (PROB_BITS >= 16) ? 0 : 16 - PROB_BITS;
	localparam int NS  = grst_pkg::FRAC_ST;
	localparam int TW  = PROB_BITS + 2;
	localparam logic [PROB_BITS-1:0] TOP = '1;

	grst_pkg::tag_t tag_y, tag_t_s, tag_p;
	logic [grst_pkg::N_W-1:0] n_y, n_t;
	logic [15:0]              f_y;
	logic [39:0]              yprod;
	logic [PROB_BITS+15:0]    rho_w;
	logic [PROB_BITS-1:0]     rho_p;
	logic [PROB_BITS+17:0]    tprod;
	logic [TW-1:0]            t_s, t_sh;
	logic [PROB_BITS-1:0]     p_s;

	grst_pkg::tag_t            tag_m [0:NS-1];
	logic [grst_pkg::M_W-1:0]  m_st  [0:NS-1];
	logic [grst_pkg::N_W-1:0]  n_m   [0:NS-1];
	logic [15:0]               f_m   [0:NS-1];

	assign yprod = 40'(x_in) * 40'(grst_pkg::LOG2E_Q16);
	assign rho_w = (PROB_BITS + 16)'(peak_survival) << SHL;
	assign rho_p = PROB_BITS'(rho_w >> SHR);
	assign tprod = (PROB_BITS + 18)'(rho_p) * (PROB_BITS + 18)'(m_st[NS-1])
		+ (PROB_BITS + 18)'(32768);
	assign t_sh  = t_s >> n_t;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_y   <= '0;
			tag_t_s <= '0;
			tag_p   <= '0;
		end else if (en) begin
			tag_y   <= tag_in;
			tag_t_s <= tag_m[NS-1];
			tag_p   <= tag_t_s;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_y <= grst_pkg::N_W'(yprod[38:32]);
			f_y <= yprod[31:16];
			t_s <= TW'(tprod >> 16);
			n_t <= n_m[NS-1];
			if (tag_t_s.wzero || n_t >= grst_pkg::N_LIMIT) p_s <= '0;
			else if (t_sh > TW'(TOP)) p_s <= TOP;
			else p_s <= PROB_BITS'(t_sh);
		end
	end

	for (genvar j = 0; j < NS; j++) begin : g_frac
		logic [grst_pkg::M_W-1:0] m_in;
		logic [grst_pkg::N_W-1:0] n_in;
		logic [15:0]              f_in;
		grst_pkg::tag_t           t_in;
		logic [32:0]              mp;

		if (j == 0) begin : g_first
			assign m_in = grst_pkg::M_ONE;
			assign n_in = n_y;
			assign f_in = f_y;
			assign t_in = tag_y;
		end else begin : g_next
			assign m_in = m_st[j-1];
			assign n_in = n_m[j-1];
			assign f_in = f_m[j-1];
			assign t_in = tag_m[j-1];
		end

		assign mp = 33'(m_in) * 33'(grst_pkg::pow2_frac(4'(j))) + 33'd32768;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) tag_m[j] <= '0;
			else if (en) tag_m[j] <= t_in;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				m_st[j] <= f_in[15-j] ? grst_pkg::M_W'(mp >> 16) : m_in;
				n_m[j]  <= n_in;
				f_m[j]  <= f_in;
			end
		end
	end

	assign tag_out = tag_p;
	assign p_out   = p_s;

endmodule

// File: rtl/grst_pow.sv
// ----------------------------------------------------------------------------
// grst_pow: compounding by squaring and the survival draw
// One stage per exponent bit, then saturation, compare and output register.
// ----------------------------------------------------------------------------
module grst_pow #(
	parameter int PROB_BITS = grst_pkg::PROB_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  grst_pkg::tag_t              tag_in,
	input  logic [PROB_BITS-1:0]        p_in,
	input  logic [grst_pkg::YEAR_W-1:0] years_per_step,
	output logic                        out_vld,
	output logic                        dies,
	output logic [15:0]                 survival_prob
);

	localparam int SHL = (PROB_BITS >= 16) ? PROB_BITS - 16 : 0;
	localparam int SHR = (PROB_BITS >= 16) ? 0 : 16 - PROB_BITS;
	localparam int NY  = grst_pkg::YEAR_W;
	localparam logic [PROB_BITS:0]   ONE = (PROB_BITS + 1)'(1) << PROB_BITS;
	localparam logic [PROB_BITS-1:0] TOP = '1;

	grst_pkg::tag_t         tag_k  [0:NY-1];
	logic [PROB_BITS:0]     acc_k  [0:NY-1];
	logic [PROB_BITS-1:0]   base_k [0:NY-1];

	grst_pkg::tag_t         tag_o;
	logic                   dies_o;
	logic [15:0]            prob_o;
	logic [PROB_BITS-1:0]   acc_sat, rnd_p;
	logic [PROB_BITS+15:0]  rnd_w, prob_w;

	for (genvar k = 0; k < NY; k++) begin : g_year
		logic [PROB_BITS:0]     a_in;
		logic [PROB_BITS-1:0]   b_in;
		grst_pkg::tag_t         t_in;
		logic [2*PROB_BITS:0]   ap;
		logic [2*PROB_BITS-1:0] bp;

		if (k == 0) begin : g_first
			assign a_in = ONE;
			assign b_in = p_in;
			assign t_in = tag_in;
		end else begin : g_next
			assign a_in = acc_k[k-1];
			assign b_in = base_k[k-1];
			assign t_in = tag_k[k-1];
		end

		assign ap = (2*PROB_BITS + 1)'(a_in) * (2*PROB_BITS + 1)'(b_in);
		assign bp = (2*PROB_BITS)'(b_in) * (2*PROB_BITS)'(b_in);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) tag_k[k] <= '0;
			else if (en) tag_k[k] <= t_in;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				acc_k[k]  <= years_per_step[k] ? (PROB_BITS + 1)'(ap >> PROB_BITS) : a_in;
				base_k[k] <= PROB_BITS'(bp >> PROB_BITS);
			end
		end
	end

	assign acc_sat = (acc_k[NY-1] > (PROB_BITS + 1)'(TOP)) ? TOP : PROB_BITS'(acc_k[NY-1]);
	assign rnd_w   = (PROB_BITS + 16)'(tag_k[NY-1].rnd) << SHL;
	assign rnd_p   = PROB_BITS'(rnd_w >> SHR);
	assign prob_w  = ((PROB_BITS + 16)'(acc_sat) >> SHL) << SHR;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tag_o <= '0;
		else if (en) tag_o <= tag_k[NY-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dies_o <= !(rnd_p < acc_sat);
			prob_o <= prob_w[15:0];
		end
	end

	assign out_vld       = tag_o.vld;
	assign dies          = dies_o;
	assign survival_prob = prob_o;

	a_zero_dies: assert property (@(posedge clk) disable iff (!arst_n)
		tag_o.vld && prob_o == '0 |-> dies_o)
		else $error("zero survival without death");

	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		!en && tag_o.vld |=> tag_o.vld && $stable(prob_o) && $stable(dies_o))
		else $error("stalled result changed");

	a_hold_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(tag_k[NY-1]))
		else $error("pipeline advanced during stall");

endmodule

// File: rtl/gaussian_resource_survival_test.sv
// ----------------------------------------------------------------------------
// gaussian_resource_survival_test: pipelined Gaussian survival draw
// Yearly survival from resource level and growth, compounded, then drawn.
// ----------------------------------------------------------------------------
// Takes one beat per cycle unless the result side stalls; returns one result beat
// per input beat, in order: 3 operand stages, 23 divider stages (overflow check
// plus one quotient bit each), 19 exp stages (one table multiply per fraction
// bit), 5 compounding stages and the output register. A result-side stall freezes
// the whole pipeline. Users must write registers only while idle (not enforced).
module gaussian_resource_survival_test #(
	parameter int FRAC_BITS = grst_pkg::FRAC_BITS_DEF,
	parameter int PROB_BITS = grst_pkg::PROB_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // resource_level, growth_value, uniform_random
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // dies, survival_prob, zero pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int WW = 33 - FRAC_BITS;
	localparam int DW = 2 * WW + 1;

	logic [15:0] peak_q, opt_q, gain_q, base_q;
	logic [grst_pkg::YEAR_W-1:0] years_q;
	logic        en, dies;
	logic [15:0] prob;

	grst_pkg::tag_t tag_in, tag_f, tag_d, tag_e;
	logic [grst_pkg::NUM_W-1:0] num_f;
	logic [DW-1:0]              den_f;
	logic [grst_pkg::X_W-1:0]   x_d;
	logic [PROB_BITS-1:0]       p_e;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q  <= 16'hFFFF;
			opt_q   <= 16'h0000;
			gain_q  <= 16'h0000;
			base_q  <= 16'h0100;
			years_q <= grst_pkg::YEAR_W'(1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				grst_pkg::REG_PEAK:  peak_q  <= cfg_data;
				grst_pkg::REG_OPT:   opt_q   <= cfg_data;
				grst_pkg::REG_GAIN:  gain_q  <= cfg_data;
				grst_pkg::REG_BASE:  base_q  <= cfg_data;
				grst_pkg::REG_YEARS: years_q <= cfg_data[grst_pkg::YEAR_W-1:0];
				default: ;
			endcase
		end
	end

	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	assign tag_in        = '{vld: s_axis_tvalid, wzero: 1'b0, rnd: s_axis_tdata[47:32]};

	grst_front #(.FRAC_BITS(FRAC_BITS), .WW(WW), .DW(DW)) u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.en                (en),
		.tag_in            (tag_in),
		.resource_level    (s_axis_tdata[15:0]),
		.growth_value      (s_axis_tdata[31:16]),
		.optimum_resource  (opt_q),
		.growth_width_gain (gain_q),
		.base_width        (base_q),
		.tag_out           (tag_f),
		.num_out           (num_f),
		.den_out           (den_f)
	);

	grst_div #(.DW(DW)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.tag_in  (tag_f),
		.num_in  (num_f),
		.den_in  (den_f),
		.tag_out (tag_d),
		.x_out   (x_d)
	);

	grst_exp #(.PROB_BITS(PROB_BITS)) u_exp (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.tag_in        (tag_d),
		.x_in          (x_d),
		.peak_survival (peak_q),
		.tag_out       (tag_e),
		.p_out         (p_e)
	);

	grst_pow #(.PROB_BITS(PROB_BITS)) u_pow (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (en),
		.tag_in         (tag_e),
		.p_in           (p_e),
		.years_per_step (years_q),
		.out_vld        (m_axis_tvalid),
		.dies           (dies),
		.survival_prob  (prob)
	);

	assign m_axis_tdata = {7'd0, prob, dies};

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: regression for the Gaussian resource survival test
// Streams tree beats through the block under many register settings and
// checks every result beat against a bit-exact fixed-point predictor.
// ----------------------------------------------------------------------------
module tb_top;

	typedef struct packed {
		logic        dies;
		logic [15:0] prob;
	} verdict_t;

	localparam int WATCHDOG = 5000;
	localparam int DRAIN = 60;

	localparam logic [15:0] EXP_TAB [16] = '{
		16'd46341, 16'd55109, 16'd60097, 16'd62757, 16'd64132, 16'd64830,
		16'd65182, 16'd65359, 16'd65447, 16'd65492, 16'd65514, 16'd65525,
		16'd65530, 16'd65533, 16'd65535, 16'd65535
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;   // resource_level, growth_value, uniform_random
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;        // dies, survival_prob, zero pad
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	logic [15:0] rho, mu, delta, sigma;
	logic [4:0]  years;

	verdict_t verdicts[$];
	int mismatches = 0;
	int items_sent = 0;
	int beats_seen = 0;
	int deaths_seen = 0;
	int cfg_writes = 0;
	int hold_cycles = 0;
	int stall = 0;
	bit quiet = 1'b0;
	int idle_cnt = 0;

	gaussian_resource_survival_test dut (.*);

	always #6 clk = ~clk;

	function automatic logic [15:0] yearly_p(logic [15:0] r, logic [15:0] g);
		longint unsigned d, w, x, y, m, p;
		int n;
		logic [15:0] f;
		d = (r >= mu) ? r - mu : mu - r;
		w = ((64'(delta) * g) >> grst_pkg::FRAC_BITS_DEF) + sigma;
		if (w == 0)
			return 16'd0;
		x = ((d * d) << 16) / (2 * w * w);
		if (x > (64'd64 << 16))
			x = 64'd64 << 16;
		y = (x * 94548) >> 16;
		n = int'(y >> 16);
		f = y[15:0];
		m = 65536;
		for (int i = 0; i < 16; i++)
			if (f[15 - i])
				m = (m * EXP_TAB[i] + 32768) >> 16;
		if (n >= 40)
			return 16'd0;
		p = ((64'(rho) * m + 32768) >> 16) >> n;
		if (p > 65535)
			p = 65535;
		return p[15:0];
	endfunction

	function automatic logic [15:0] compound_p(logic [15:0] r, logic [15:0] g);
		longint unsigned b, acc;
		logic [4:0] e;
		b = yearly_p(r, g);
		acc = 65536;
		e = years;
		while (e != 0) begin
			if (e[0])
				acc = (acc * b) >> 16;
			b = (b * b) >> 16;
			e = e >> 1;
		end
		if (acc > 65535)
			acc = 65535;
		return acc[15:0];
	endfunction

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
		    (cfg_valid && cfg_ready))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= WATCHDOG) begin
			$display("watchdog: no beat for %0d cycles", WATCHDOG);
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			beats_seen++;
			if (m_axis_tdata[0])
				deaths_seen++;
			if (verdicts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat %h", m_axis_tdata);
			end else begin
				verdict_t v;
				v = verdicts.pop_front();
				if (m_axis_tdata[0] !== v.dies || m_axis_tdata[16:1] !== v.prob ||
				    m_axis_tdata[23:17] !== '0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("beat %0d: expected dies=%0d prob=%0d, got dies=%0d prob=%0d pad=%h",
						         beats_seen, v.dies, v.prob, m_axis_tdata[0],
						         m_axis_tdata[16:1], m_axis_tdata[23:17]);
				end
			end
			stall = quiet ? 0 : $urandom_range(0, 17);
		end
		if (hold_cycles > 0) begin
			hold_cycles--;
			m_axis_tready <= 1'b0;
		end else if (stall > 0) begin
			stall--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= arst_n;
		end
	end

	task automatic send_item(logic [15:0] r, logic [15:0] g, logic [15:0] u, bit nogap = 0);
		int gap;
		gap = (quiet || nogap) ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {u, g, r};
		do @(posedge clk); while (!s_axis_tready);
		begin
			verdict_t v;
			v.prob = compound_p(r, g);
			v.dies = !(u < v.prob);
			verdicts.push_back(v);
		end
		items_sent++;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (verdicts.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		cfg_writes++;
		unique case (idx)
			grst_pkg::REG_PEAK:  rho = val;
			grst_pkg::REG_OPT:   mu = val;
			grst_pkg::REG_GAIN:  delta = val;
			grst_pkg::REG_BASE:  sigma = val;
			grst_pkg::REG_YEARS: years = val[4:0];
			default: ;
		endcase
	endtask

	task automatic set_all(logic [15:0] p, logic [15:0] o, logic [15:0] gn,
	                       logic [15:0] b, logic [15:0] y);
		write_reg(grst_pkg::REG_PEAK, p);
		write_reg(grst_pkg::REG_OPT, o);
		write_reg(grst_pkg::REG_GAIN, gn);
		write_reg(grst_pkg::REG_BASE, b);
		write_reg(grst_pkg::REG_YEARS, y);
	endtask

	// random tree, mostly near the optimum, draw sometimes on the decision boundary
	task automatic send_random(bit nogap = 0);
		logic [15:0] r, g, u, p;
		int off, span;
		g = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1024));
		if ($urandom_range(0, 9) < 7) begin
			span = 4 * (((int'(delta) * g) >> 8) + sigma) + 4;
			if (span > 65535)
				span = 65535;
			off = $urandom_range(0, span);
			if ($urandom_range(0, 1))
				r = (int'(mu) + off > 65535) ? 16'hFFFF : 16'(mu + off);
			else
				r = (off > mu) ? 16'd0 : 16'(mu - off);
		end else begin
			r = 16'($urandom);
		end
		p = compound_p(r, g);
		case ($urandom_range(0, 5))
			0: u = p;
			1: u = p - 1;
			default: u = 16'($urandom);
		endcase
		send_item(r, g, u, nogap);
	endtask

	task automatic test_directed();
		send_item(16'd0, 16'd0, 16'd0);
		send_item(16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_item(16'd0, 16'd0, 16'hFFFF);
		send_item(16'd256, 16'd0, 16'hFFFE);
		send_item(16'd200, 16'd0, 16'd30000);
		send_item(16'hFFFF, 16'd0, 16'd0);
		drain();
		set_all(16'hFFFF, 16'd1000, 16'd0, 16'd0, 16'd1);
		send_item(16'd1000, 16'd0, 16'd0);
		send_item(16'd1000, 16'd5, 16'd0);
		drain();
		set_all(16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd31);
		send_item(16'hFFFF, 16'hFFFF, 16'd0);
		send_item(16'd0, 16'hFFFF, 16'h7FFF);
		send_item(16'hFFFF, 16'd0, 16'h8000);
		drain();
		set_all(16'd0, 16'd0, 16'd0, 16'd1, 16'h0020);
		write_reg(3'd5, 16'hFFFF);
		write_reg(3'd6, 16'h1234);
		write_reg(3'd7, 16'h0000);
		send_item(16'd0, 16'd0, 16'd0);
		send_item(16'hFFFF, 16'd0, 16'd0);
		drain();
		set_all(16'hFFFF, 16'd512, 16'd256, 16'd1, 16'h0021);
		send_item(16'd512, 16'd0, 16'hFFFE);
		send_item(16'd520, 16'd2, 16'd1000);
		send_item(16'd0, 16'd0, 16'd0);
		drain();
	endtask

	task automatic test_sweep();
		for (int ph = 0; ph < 12; ph++) begin
			quiet = (ph % 3 == 2);
			set_all(($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom),
			        16'($urandom),
			        ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 512)),
			        ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 4096)),
			        ($urandom_range(0, 4) == 0) ? 16'd31 : 16'($urandom_range(1, 31)));
			repeat (65) send_random();
			drain();
		end
		quiet = 1'b0;
	endtask

	task automatic test_backpressure();
		set_all(16'hF000, 16'd2000, 16'd64, 16'd300, 16'd3);
		hold_cycles = 300;
		repeat (80) send_random(1);
		drain();
	endtask

	initial begin
		rho = 16'hFFFF;
		mu = 16'd0;
		delta = 16'd0;
		sigma = 16'd256;
		years = 5'd1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_sweep();
		test_backpressure();
		drain();
		$display("covered %0d trees (%0d deaths) over %0d register writes",
		         items_sent, deaths_seen, cfg_writes);
		$display("including zero width, zero and maximum years, and a long output stall");
		if (mismatches == 0 && verdicts.size() == 0 && beats_seen == items_sent) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches, %0d results outstanding", mismatches, verdicts.size());
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
